// ----- rtl/core/tcfh_pkg.sv -----
// Shared types, constants and helper functions of the two-choice fingerprint hash table.
`default_nettype none
package tcfh_pkg;

  localparam int MAX_BUCKETS = 1024;
  localparam int BKT_LOG     = $clog2(MAX_BUCKETS);
  localparam int SLOTS       = 8;
  localparam int SLOT_LOG    = $clog2(SLOTS);
  localparam int SLOT_CNT_W  = $clog2(SLOTS + 1);
  localparam int ROWS        = 2 * MAX_BUCKETS;
  localparam int ROW_AW      = $clog2(ROWS);
  localparam int WORD_W      = 32;
  localparam int ROW_W       = SLOTS * WORD_W;
  localparam int PAIR_DEPTH  = 8192;
  localparam int PAIR_AW     = $clog2(PAIR_DEPTH);
  localparam int KEY_W       = 128;
  localparam int VAL_W       = 64;
  localparam int HALF_KEY_W  = KEY_W / 2;
  localparam int CAND_N      = 2 * SLOTS;
  localparam int CAND_W      = $clog2(CAND_N);
  localparam int CAP_W       = 13;
  localparam int KB_W        = 5;
  localparam int VB_W        = 4;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int NB_LOG_W    = $clog2(BKT_LOG + 1);
  localparam int KEY_BYTES   = KEY_W / 8;
  localparam int VAL_BYTES   = VAL_W / 8;

  localparam logic [63:0] HASH_SEED = 64'h0000_0000_a963_47c5;
  localparam logic [63:0] MM_C1     = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MM_C2     = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] MM_F1     = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] MM_F2     = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [63:0] MM_ADD1   = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] MM_ADD2   = 64'h0000_0000_3849_5ab5;

  typedef enum logic [1:0] {
    REQ_GET   = 2'd0,
    REQ_PUT   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_code_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_STORE_FULL = 3'd3,
    ST_BKT_FULL = 3'd4,
    ST_CLEARED  = 3'd5
  } st_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY    = 2'd0,
    CFG_KEY_BYTES   = 2'd1,
    CFG_VALUE_BYTES = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [63:0] value_in;
  } tcfh_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [PAIR_AW-1:0] pair_index;
    logic [63:0]        value_out;
  } tcfh_out_t;

  typedef struct packed {
    logic     latch_req;
    logic     hash_start;
    logic     rd_en;
    logic     rd_sel;
    logic     cap0;
    logic     cap1;
    logic     cand_init;
    logic     key_rd;
    logic     cand_drop;
    logic     put_write;
    logic     clr_step;
    logic     res_load;
    st_code_t res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       store_full;
    logic       hash_done;
    logic       cand_any;
    logic       key_match;
    logic       bkt_full;
    logic       clr_last;
    logic       out_free;
  } dp_stat_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  // low n bytes set
  function automatic logic [63:0] byte_mask(input logic [KB_W-1:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (n > KB_W'(b)) m[8*b +: 8] = 8'hff;
    end
    return m;
  endfunction

  // log2 of buckets per half: smallest power of two >= 4 with SLOTS*nb > cap
  function automatic logic [NB_LOG_W-1:0] nb_log(input logic [CAP_W-1:0] cap);
    logic [NB_LOG_W-1:0] r;
    r = NB_LOG_W'(BKT_LOG);
    for (int l = BKT_LOG; l >= 2; l--) begin
      if ((32'(SLOTS) << l) > 32'(cap)) r = NB_LOG_W'(l);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tcfh_murmur.sv -----
// Iterative 128-bit murmur hash unit with one shared 32x32 multiplier.
`default_nettype none
module tcfh_murmur (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] key_lo,
  input  wire logic [63:0] key_hi,
  input  wire logic [tcfh_pkg::KB_W-1:0] key_len,
  output logic             done,
  output logic [63:0]      hash0,
  output logic [63:0]      hash1
);
  import tcfh_pkg::*;

  typedef enum logic [3:0] {
    IDLE, K1A, K1B, H1MIX, K2A, K2B, H2MIX, FIN0, FIN1, FPRE, FMA, FMB, ADD0, ADD1
  } state_t;

  state_t      state;
  logic [1:0]  ph;
  logic [63:0] h1, h2, k, acc;
  logic        fm_sel;

  logic [63:0] ma, mb, prod, mres, mix1, mix2, t1, t2, len64, fx, mres_x;
  logic [31:0] pa, pb;
  logic        is_mul, len16, len_gt8;

  assign len16   = (key_len == KB_W'(16));
  assign len_gt8 = (key_len > KB_W'(8));
  assign len64   = 64'(key_len);
  assign is_mul  = (state == K1A) || (state == K1B) || (state == K2A) ||
                   (state == K2B) || (state == FMA) || (state == FMB);

  always_comb begin
    case (state)
      K1A:     ma = key_lo;
      K2A:     ma = key_hi;
      default: ma = k;
    endcase
    case (state)
      K1A:     mb = MM_C1;
      K1B:     mb = MM_C2;
      K2A:     mb = MM_C2;
      K2B:     mb = MM_C1;
      FMA:     mb = MM_F1;
      FMB:     mb = MM_F2;
      default: mb = '0;
    endcase
  end

  // low 64 bits of ma*mb over three partial products
  assign pa     = (ph == 2'd2) ? ma[63:32] : ma[31:0];
  assign pb     = (ph == 2'd1) ? mb[63:32] : mb[31:0];
  assign prod   = 64'(pa) * 64'(pb);
  assign mres   = {acc[63:32] + prod[31:0], acc[31:0]};
  assign mres_x = mres ^ (mres >> 33);

  assign t1   = rotl64(h1, 27) + h2;
  assign mix1 = t1 + (t1 << 2) + MM_ADD1;
  assign t2   = rotl64(h2, 31) + h1;
  assign mix2 = t2 + (t2 << 2) + MM_ADD2;
  assign fx   = fm_sel ? h2 : h1;

  assign hash0 = h1;
  assign hash1 = h2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      ph     <= 2'd0;
      done   <= 1'b0;
      fm_sel <= 1'b0;
    end else begin
      done <= (state == ADD1);
      if (is_mul) begin
        if (ph == 2'd0) begin
          acc <= prod;
          ph  <= 2'd1;
        end else if (ph == 2'd1) begin
          acc[63:32] <= acc[63:32] + prod[31:0];
          ph         <= 2'd2;
        end else begin
          ph <= 2'd0;
        end
      end
      case (state)
        IDLE: begin
          if (start) begin
            h1     <= HASH_SEED;
            h2     <= HASH_SEED;
            ph     <= 2'd0;
            fm_sel <= 1'b0;
            state  <= K1A;
          end
        end
        K1A: begin
          if (ph == 2'd2) begin
            k     <= rotl64(mres, 31);
            state <= K1B;
          end
        end
        K1B: begin
          if (ph == 2'd2) begin
            h1 <= h1 ^ mres;
            if (len16)        state <= H1MIX;
            else if (len_gt8) state <= K2A;
            else              state <= FIN0;
          end
        end
        H1MIX: begin
          h1    <= mix1;
          state <= K2A;
        end
        K2A: begin
          if (ph == 2'd2) begin
            k     <= rotl64(mres, 33);
            state <= K2B;
          end
        end
        K2B: begin
          if (ph == 2'd2) begin
            h2    <= h2 ^ mres;
            state <= len16 ? H2MIX : FIN0;
          end
        end
        H2MIX: begin
          h2    <= mix2;
          state <= FIN0;
        end
        FIN0: begin
          h1    <= (h1 ^ len64) + (h2 ^ len64);
          h2    <= h2 ^ len64;
          state <= FIN1;
        end
        FIN1: begin
          h2    <= h2 + h1;
          state <= FPRE;
        end
        FPRE: begin
          k     <= fx ^ (fx >> 33);
          state <= FMA;
        end
        FMA: begin
          if (ph == 2'd2) begin
            k     <= mres_x;
            state <= FMB;
          end
        end
        FMB: begin
          if (ph == 2'd2) begin
            if (fm_sel) begin
              h2    <= mres_x;
              state <= ADD0;
            end else begin
              h1     <= mres_x;
              fm_sel <= 1'b1;
              state  <= FPRE;
            end
          end
        end
        ADD0: begin
          h1    <= h1 + h2;
          state <= ADD1;
        end
        ADD1: begin
          h2    <= h2 + h1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tcfh_datapath.sv -----
// Datapath: config registers, request latch, hash unit, bucket/key/value memories, output register.
`default_nettype none
module tcfh_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [tcfh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcfh_pkg::CFG_W-1:0]      cfg_data,
  input  wire tcfh_pkg::tcfh_in_t              in_data,
  input  wire tcfh_pkg::dp_cmd_t               cmd,
  output tcfh_pkg::dp_stat_t                   stat,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output tcfh_pkg::tcfh_out_t                  out_data
);
  import tcfh_pkg::*;

  // configuration
  logic [CAP_W-1:0] capacity;
  logic [KB_W-1:0]  key_bytes;
  logic [VB_W-1:0]  value_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAP_W'(8191);
      key_bytes   <= KB_W'(KEY_BYTES);
      value_bytes <= VB_W'(VAL_BYTES);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CAPACITY:    capacity    <= cfg_data[CAP_W-1:0];
        CFG_KEY_BYTES:   key_bytes   <= cfg_data[KB_W-1:0];
        CFG_VALUE_BYTES: value_bytes <= cfg_data[VB_W-1:0];
        default: ;
      endcase
    end
  end

  logic [KB_W-1:0] kb_c;
  logic [VB_W-1:0] vb_c;
  assign kb_c = (key_bytes == '0) ? KB_W'(1) :
                (key_bytes > KB_W'(KEY_BYTES)) ? KB_W'(KEY_BYTES) : key_bytes;
  assign vb_c = (value_bytes == '0) ? VB_W'(1) :
                (value_bytes > VB_W'(VAL_BYTES)) ? VB_W'(VAL_BYTES) : value_bytes;

  // request latch, key and value masked to their lengths
  logic [1:0]      req_type;
  logic [63:0]     key_lo, key_hi, val;
  logic [KB_W-1:0] key_len;

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_type <= in_data.req_type;
      key_lo   <= in_data.key_low & byte_mask(kb_c);
      key_hi   <= (kb_c > KB_W'(8)) ? (in_data.key_high & byte_mask(kb_c - KB_W'(8))) : '0;
      val      <= in_data.value_in & byte_mask(KB_W'(vb_c));
      key_len  <= kb_c;
    end
  end

  logic        hash_done;
  logic [63:0] hash0, hash1;

  tcfh_murmur u_murmur (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.hash_start),
    .key_lo  (key_lo),
    .key_hi  (key_hi),
    .key_len (key_len),
    .done    (hash_done),
    .hash0   (hash0),
    .hash1   (hash1)
  );

  // table geometry from capacity
  logic [NB_LOG_W-1:0] nbl;
  logic [ROW_AW-1:0]   nb;
  logic [BKT_LOG-1:0]  nb_mask;
  logic [WORD_W-1:0]   kvx, fp_mask, fp0, fp1;
  logic [ROW_AW-1:0]   b0, b1;

  assign nbl     = nb_log(capacity);
  assign nb      = ROW_AW'(1) << nbl;
  assign nb_mask = BKT_LOG'(nb - ROW_AW'(1));
  assign kvx     = (WORD_W'(SLOTS) << nbl) - WORD_W'(1);
  assign fp_mask = ~kvx;
  assign fp0     = hash0[WORD_W-1:0] & fp_mask;
  assign fp1     = hash1[WORD_W-1:0] & fp_mask;
  assign b0      = ROW_AW'(hash1[32 +: BKT_LOG] & nb_mask);
  assign b1      = ROW_AW'(hash0[32 +: BKT_LOG] & nb_mask) + nb;

  // bucket rows, one bucket per row
  logic [ROW_W-1:0]  bkt_mem [ROWS];
  logic [ROW_W-1:0]  rd_row, row0, row1, new_row, base_row;
  logic [ROW_AW-1:0] clr_cnt, bw_addr;
  logic [ROW_W-1:0]  bw_data;
  logic              bw_en;

  logic [SLOTS-1:0]      z0, z1, m0, m1;
  logic [SLOT_CNT_W-1:0] n0, n1;
  logic [SLOT_LOG-1:0]   i0, i1, isel;
  logic                  use0;
  logic [PAIR_AW-1:0]    next_free;
  logic [WORD_W-1:0]     new_word;

  always_comb begin
    i0 = '0;
    i1 = '0;
    for (int i = 0; i < SLOTS; i++) begin
      z0[i] = (row0[WORD_W*i +: WORD_W] == '0);
      z1[i] = (row1[WORD_W*i +: WORD_W] == '0);
      m0[i] = !z0[i] && ((row0[WORD_W*i +: WORD_W] & fp_mask) == fp0);
      m1[i] = !z1[i] && ((row1[WORD_W*i +: WORD_W] & fp_mask) == fp1);
      if (z0[i]) i0 = SLOT_LOG'(i);
      if (z1[i]) i1 = SLOT_LOG'(i);
    end
  end

  assign n0       = SLOT_CNT_W'($countones(z0));
  assign n1       = SLOT_CNT_W'($countones(z1));
  assign use0     = (n0 >= n1);
  assign isel     = use0 ? i0 : i1;
  assign base_row = use0 ? row0 : row1;
  assign new_word = (use0 ? fp0 : fp1) | (WORD_W'(next_free) & kvx);

  always_comb begin
    new_row = base_row;
    for (int i = 0; i < SLOTS; i++) begin
      if (isel == SLOT_LOG'(i)) new_row[WORD_W*i +: WORD_W] = new_word;
    end
  end

  assign bw_en   = cmd.clr_step || cmd.put_write;
  assign bw_addr = cmd.clr_step ? clr_cnt : (use0 ? b0 : b1);
  assign bw_data = cmd.clr_step ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (bw_en) bkt_mem[bw_addr] <= bw_data;
    if (cmd.rd_en) rd_row <= bkt_mem[cmd.rd_sel ? b1 : b0];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap0) row0 <= rd_row;
    if (cmd.cap1) row1 <= rd_row;
  end

  // candidates in probe order: for each slot i in turn, slot i of first bucket, then of second
  logic [CAND_N-1:0] cand;
  logic [CAND_W-1:0] csel;
  logic [WORD_W-1:0] cword;
  logic [PAIR_AW-1:0] cand_k;

  always_comb begin
    csel = '0;
    for (int j = CAND_N - 1; j >= 0; j--) begin
      if (cand[j]) csel = CAND_W'(j);
    end
  end

  assign cword  = csel[0] ? row1[WORD_W*csel[CAND_W-1:1] +: WORD_W]
                          : row0[WORD_W*csel[CAND_W-1:1] +: WORD_W];
  assign cand_k = cword[PAIR_AW-1:0] & kvx[PAIR_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.cand_init) begin
      for (int i = 0; i < SLOTS; i++) begin
        cand[2*i]     <= m0[i];
        cand[2*i + 1] <= m1[i];
      end
    end else if (cmd.cand_drop) begin
      cand[csel] <= 1'b0;
    end
  end

  // pair stores
  logic [KEY_W-1:0]   key_mem [PAIR_DEPTH];
  logic [VAL_W-1:0]   val_mem [PAIR_DEPTH];
  logic [KEY_W-1:0]   key_rd_data;
  logic [VAL_W-1:0]   val_rd_data;
  logic [PAIR_AW-1:0] pair_sel;

  always_ff @(posedge clk) begin
    if (cmd.put_write) begin
      key_mem[next_free] <= {key_hi, key_lo};
      val_mem[next_free] <= val;
    end
    if (cmd.key_rd) begin
      key_rd_data <= key_mem[cand_k];
      val_rd_data <= val_mem[cand_k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_rd) pair_sel <= cand_k;
    else if (cmd.put_write) pair_sel <= next_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= '0;
      clr_cnt   <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + ROW_AW'(1);
      if (cmd.put_write) next_free <= next_free + PAIR_AW'(1);
      else if (cmd.clr_step && stat.clr_last) next_free <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data.status     <= cmd.res_code;
      out_data.pair_index <= (cmd.res_code == ST_HIT || cmd.res_code == ST_INSERTED) ?
                             pair_sel : '0;
      out_data.value_out  <= (cmd.res_code == ST_HIT) ? val_rd_data : '0;
    end
  end

  assign stat.req_type   = req_type;
  assign stat.store_full = (13'(next_free) >= capacity);
  assign stat.hash_done  = hash_done;
  assign stat.cand_any   = |cand;
  assign stat.key_match  = (key_rd_data == {key_hi, key_lo});
  assign stat.bkt_full   = (z0 == '0) && (z1 == '0);
  assign stat.clr_last   = (clr_cnt == ROW_AW'(ROWS - 1));
  assign stat.out_free   = !out_valid || !out_stall;

endmodule
`default_nettype wire

// ----- rtl/core/tcfh_ctrl.sv -----
// Controller state machine: sequences hash, bucket reads, key probes, insert and clearing.
`default_nettype none
module tcfh_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tcfh_pkg::dp_stat_t stat,
  output tcfh_pkg::dp_cmd_t       cmd
);
  import tcfh_pkg::*;

  typedef enum logic [3:0] {
    BOOT_CLR, IDLE, DECIDE, HASH, RD0, RD1, RD2, EVAL, GSEL, GCMP, CLR, RESULT
  } state_t;

  state_t   state;
  st_code_t res_code;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd          = '0;
    cmd.res_code = res_code;
    case (state)
      BOOT_CLR, CLR: cmd.clr_step = 1'b1;
      IDLE:   cmd.latch_req = in_valid;
      DECIDE: cmd.hash_start = (stat.req_type == REQ_GET) ||
                               (stat.req_type == REQ_PUT && !stat.store_full);
      RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 1'b0;
      end
      RD1: begin
        cmd.cap0   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 1'b1;
      end
      RD2:    cmd.cap1 = 1'b1;
      EVAL: begin
        cmd.cand_init = (stat.req_type == REQ_GET);
        cmd.put_write = (stat.req_type == REQ_PUT) && !stat.bkt_full;
      end
      GSEL:   cmd.key_rd = stat.cand_any;
      GCMP:   cmd.cand_drop = !stat.key_match;
      RESULT: cmd.res_load = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BOOT_CLR;
      res_code <= ST_MISS;
    end else begin
      case (state)
        BOOT_CLR: if (stat.clr_last) state <= IDLE;
        IDLE:     if (in_valid) state <= DECIDE;
        DECIDE: begin
          case (stat.req_type)
            REQ_CLEAR: state <= CLR;
            REQ_GET:   state <= HASH;
            REQ_PUT: begin
              if (stat.store_full) begin
                res_code <= ST_STORE_FULL;
                state    <= RESULT;
              end else begin
                state <= HASH;
              end
            end
            default: begin
              res_code <= ST_MISS;
              state    <= RESULT;
            end
          endcase
        end
        HASH: if (stat.hash_done) state <= RD0;
        RD0:  state <= RD1;
        RD1:  state <= RD2;
        RD2:  state <= EVAL;
        EVAL: begin
          if (stat.req_type == REQ_GET) begin
            state <= GSEL;
          end else begin
            res_code <= stat.bkt_full ? ST_BKT_FULL : ST_INSERTED;
            state    <= RESULT;
          end
        end
        GSEL: begin
          if (stat.cand_any) begin
            state <= GCMP;
          end else begin
            res_code <= ST_MISS;
            state    <= RESULT;
          end
        end
        GCMP: begin
          if (stat.key_match) begin
            res_code <= ST_HIT;
            state    <= RESULT;
          end else begin
            state <= GSEL;
          end
        end
        CLR: begin
          if (stat.clr_last) begin
            res_code <= ST_CLEARED;
            state    <= RESULT;
          end
        end
        RESULT: if (stat.out_free) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/two_choice_fingerprint_hash_table.sv -----
// Top level of the two-choice fingerprint hash table engine.
//
// Usage: one request transaction in (in_valid/in_stall, in_data), one
// result transaction out (out_valid/out_stall, out_data) per request.
// A transaction moves on a rising edge with valid high and stall low.
// Requests are get, put and clear; keys are hashed with a 128-bit murmur
// hash into one bucket in each half of the bucket rows in use.
// Configuration (capacity, key_bytes, value_bytes) is written through
// cfg_write/cfg_index/cfg_data; the user must write it only while the
// engine is idle; the block itself does not enforce this.
// The hash unit shares one 32x32 multiplier over up to eight 64-bit
// products; bucket reads and decision follow. A get probes each
// fingerprint candidate in the key store in turn (up to 16).
// One request is in flight at a time; the next is taken once the result
// is in the output register, even if the receiver still stalls it.
// A held result blocks only the completion of the following request.
// Reset: registers return to defaults and a clearing pass zeroes the
// bucket store, one bucket row per cycle, with in_stall high throughout.
// A clear request runs the same pass.
// Pair key/value stores are never cleared: only reachable pairs are read.
`default_nettype none
module two_choice_fingerprint_hash_table (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire tcfh_pkg::tcfh_in_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output tcfh_pkg::tcfh_out_t                 out_data,
  input  wire logic                           cfg_write,
  input  wire logic [tcfh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcfh_pkg::CFG_W-1:0]     cfg_data
);
  import tcfh_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing only; all storage and arithmetic sit in the datapath
  tcfh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcfh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
